// ===== hw/rtl/mhc_pkg.sv =====
`default_nettype none
package mhc_pkg;

    // Word and table geometry
    localparam int DW              = 64;
    localparam int NCOEF           = 10;
    localparam int COEF_HIGH_OFS   = 5;
    localparam int SPECIES_MAX_DEF = 16;
    localparam int SPECIES_LIMIT   = 256;
    localparam int ADDR_W          = $clog2(SPECIES_LIMIT * NCOEF);
    localparam int QDEPTH          = 2;

    // Register map
    localparam int PADDR_W          = 4;
    localparam logic REG_GAS_CONSTANT = 1'b0;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ACCUM = 1'b1;

    // Temperature range bounds and IEEE constants
    localparam logic [DW-1:0] T_200_BITS   = 64'h4069_0000_0000_0000;
    localparam logic [DW-1:0] T_1000_BITS  = 64'h408F_4000_0000_0000;
    localparam logic [DW-1:0] T_5000_BITS  = 64'h40B3_8800_0000_0000;
    localparam logic [DW-1:0] DEFAULT_QNAN = 64'hFFF8_0000_0000_0000;
    localparam logic [DW-1:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

    typedef enum logic [1:0] {
        K_LOAD,
        K_TERM,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [DW-1:0]      data;
        logic [DW-1:0]      frac;
        logic               last;
    } t_entry;

    // Count leading zeros of a product word
    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] n;
        n = 7'd106;
        for (int i = 0; i < 106; i++) begin
            if (v[i]) begin
                n = 7'(105 - i);
            end
        end
        return n;
    endfunction

    // Count leading zeros of a sum word
    function automatic logic [5:0] lzc57(input logic [56:0] v);
        logic [5:0] n;
        n = 6'd57;
        for (int i = 0; i < 57; i++) begin
            if (v[i]) begin
                n = 6'(56 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mhc_fpmul.sv =====
`default_nettype none
module mhc_fpmul (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [63:0]          i_a,
    input  wire logic [63:0]          i_b,
    output logic                      o_done,
    output logic [63:0]               o_res
);
    import mhc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_NORM,
        S_ROUND,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [1:0]          r_cnt;
    logic                r_sign;
    logic [52:0]         r_ma;
    logic [53:0]         r_mb;
    logic [105:0]        r_acc;
    logic [105:0]        r_norm;
    logic signed [12:0]  r_e;
    logic [63:0]         r_res;

    // Operand classification
    logic [10:0] ea, eb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
    always_comb begin
        ea     = i_a[62:52];
        eb     = i_b[62:52];
        nan_a  = (&ea) && (|i_a[51:0]);
        nan_b  = (&eb) && (|i_b[51:0]);
        inf_a  = (&ea) && !(|i_a[51:0]);
        inf_b  = (&eb) && !(|i_b[51:0]);
        zero_a = !(|i_a[62:0]);
        zero_b = !(|i_b[62:0]);
        sgn    = i_a[63] ^ i_b[63];
    end

    // Partial product of one 18-bit slice
    logic [17:0]  chunk;
    logic [70:0]  pp;
    logic [105:0] ppx;
    always_comb begin
        case (r_cnt)
            2'd0:    chunk = r_mb[17:0];
            2'd1:    chunk = r_mb[35:18];
            2'd2:    chunk = r_mb[53:36];
            default: chunk = '0;
        endcase
        pp = r_ma * chunk;
        case (r_cnt)
            2'd0:    ppx = 106'(pp);
            2'd1:    ppx = 106'(pp) << 18;
            2'd2:    ppx = 106'(pp) << 36;
            default: ppx = '0;
        endcase
    end

    // Denormalize and round to nearest even
    logic signed [12:0] rs;
    logic [6:0]         shamt;
    logic [105:0]       den, mask;
    logic               lost, g, st, inc, ovf;
    logic [52:0]        m;
    logic [10:0]        expf;
    logic [62:0]        mag;
    always_comb begin
        rs    = 13'sd1 - r_e;
        shamt = '0;
        mask  = '0;
        den   = r_norm;
        lost  = 1'b0;
        expf  = r_e[10:0];
        if (r_e <= 13'sd0) begin
            shamt = (rs > 13'sd107) ? 7'd107 : rs[6:0];
            den   = r_norm >> shamt;
            mask  = ~({106{1'b1}} << shamt);
            lost  = |(r_norm & mask);
            expf  = '0;
        end
        m   = den[105:53];
        g   = den[52];
        st  = (|den[51:0]) | lost;
        inc = g & (st | m[0]);
        mag = {expf, m[51:0]} + 63'(inc);
        ovf = r_e > 13'sd2046;
    end

    // Sequence one multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sign <= sgn;
                        if (nan_a) begin
                            r_res   <= i_a | QUIET_BIT;
                            r_state <= S_FIN;
                        end else if (nan_b) begin
                            r_res   <= i_b | QUIET_BIT;
                            r_state <= S_FIN;
                        end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                            r_res   <= DEFAULT_QNAN;
                            r_state <= S_FIN;
                        end else if (inf_a || inf_b) begin
                            r_res   <= {sgn, 11'h7FF, 52'd0};
                            r_state <= S_FIN;
                        end else if (zero_a || zero_b) begin
                            r_res   <= {sgn, 63'd0};
                            r_state <= S_FIN;
                        end else begin
                            r_ma    <= {(ea != 11'd0), i_a[51:0]};
                            r_mb    <= {1'b0, (eb != 11'd0), i_b[51:0]};
                            r_e     <= 13'(signed'({2'b00, (ea == 11'd0) ? 11'd1 : ea}))
                                     + 13'(signed'({2'b00, (eb == 11'd0) ? 11'd1 : eb}))
                                     - 13'sd1022;
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_MULT;
                        end
                    end
                end
                S_MULT: begin
                    r_acc <= r_acc + ppx;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_norm  <= r_acc << lzc106(r_acc);
                    r_e     <= r_e - 13'(signed'({6'd0, lzc106(r_acc)}));
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_res   <= ovf ? {r_sign, 11'h7FF, 52'd0} : {r_sign, mag};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_FIN);
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== hw/rtl/mhc_fpadd.sv =====
`default_nettype none
module mhc_fpadd (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [63:0]          i_a,
    input  wire logic [63:0]          i_b,
    output logic                      o_done,
    output logic [63:0]               o_res
);
    import mhc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_SUM,
        S_NORM,
        S_ROUND,
        S_FIN
    } t_state;

    t_state       r_state;
    logic         r_sa, r_sb, r_sub;
    logic [10:0]  r_eb, r_es;
    logic [52:0]  r_mbig, r_msmall;
    logic [55:0]  r_mb56, r_ms56;
    logic [56:0]  r_sum;
    logic [55:0]  r_n;
    logic [11:0]  r_e;
    logic [63:0]  r_res;

    // Operand classification and magnitude order
    logic [10:0] ea, eb;
    logic        nan_a, nan_b, inf_a, inf_b, a_big;
    logic [63:0] big, lesser;
    always_comb begin
        ea     = i_a[62:52];
        eb     = i_b[62:52];
        nan_a  = (&ea) && (|i_a[51:0]);
        nan_b  = (&eb) && (|i_b[51:0]);
        inf_a  = (&ea) && !(|i_a[51:0]);
        inf_b  = (&eb) && !(|i_b[51:0]);
        a_big  = i_a[62:0] >= i_b[62:0];
        big    = a_big ? i_a : i_b;
        lesser = a_big ? i_b : i_a;
    end

    // Align the smaller operand with sticky collection
    logic [10:0] d;
    logic [5:0]  dcl;
    logic [55:0] ms, msh, amask;
    always_comb begin
        d     = r_eb - r_es;
        dcl   = (d > 11'd56) ? 6'd57 : d[5:0];
        ms    = {r_msmall, 3'b000};
        msh   = ms >> dcl;
        amask = ~({56{1'b1}} << dcl);
    end

    // Normalize shift amount
    logic [5:0]  lz, k;
    logic [10:0] shn;
    always_comb begin
        lz  = lzc57(r_sum);
        k   = lz - 6'd1;
        shn = (11'(k) < r_eb) ? 11'(k) : (r_eb - 11'd1);
    end

    // Round to nearest even
    logic [52:0] m;
    logic        g, st, inc, ovf;
    logic [10:0] expf;
    logic [62:0] mag;
    always_comb begin
        m    = r_n[55:3];
        g    = r_n[2];
        st   = |r_n[1:0];
        inc  = g & (st | m[0]);
        expf = r_n[55] ? r_e[10:0] : 11'd0;
        mag  = {expf, m[51:0]} + 63'(inc);
        ovf  = r_e >= 12'd2047;
    end

    // Sequence one addition
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (nan_a) begin
                            r_res   <= i_a | QUIET_BIT;
                            r_state <= S_FIN;
                        end else if (nan_b) begin
                            r_res   <= i_b | QUIET_BIT;
                            r_state <= S_FIN;
                        end else if (inf_a && inf_b && (i_a[63] != i_b[63])) begin
                            r_res   <= DEFAULT_QNAN;
                            r_state <= S_FIN;
                        end else if (inf_a) begin
                            r_res   <= i_a;
                            r_state <= S_FIN;
                        end else if (inf_b) begin
                            r_res   <= i_b;
                            r_state <= S_FIN;
                        end else begin
                            r_sa     <= big[63];
                            r_sb     <= lesser[63];
                            r_sub    <= big[63] ^ lesser[63];
                            r_eb     <= (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
                            r_es     <= (lesser[62:52] == 11'd0) ? 11'd1 : lesser[62:52];
                            r_mbig   <= {(big[62:52] != 11'd0), big[51:0]};
                            r_msmall <= {(lesser[62:52] != 11'd0), lesser[51:0]};
                            r_state  <= S_ALIGN;
                        end
                    end
                end
                S_ALIGN: begin
                    r_mb56  <= {r_mbig, 3'b000};
                    r_ms56  <= msh | {55'd0, |(ms & amask)};
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= r_sub ? ({1'b0, r_mb56} - {1'b0, r_ms56})
                                     : ({1'b0, r_mb56} + {1'b0, r_ms56});
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_sum == 57'd0) begin
                        r_res   <= {r_sa & r_sb, 63'd0};
                        r_state <= S_FIN;
                    end else if (r_sum[56]) begin
                        r_n     <= r_sum[56:1] | {55'd0, r_sum[0]};
                        r_e     <= {1'b0, r_eb} + 12'd1;
                        r_state <= S_ROUND;
                    end else begin
                        r_n     <= r_sum[55:0] << shn;
                        r_e     <= {1'b0, r_eb - shn};
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_res   <= ovf ? {r_sa, 11'h7FF, 52'd0} : {r_sa, mag};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_FIN);
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== hw/rtl/mhc_queue.sv =====
`default_nettype none
module mhc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mhc_pkg::t_entry    i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output mhc_pkg::t_entry         o_data
);
    import mhc_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_entry           r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];

endmodule
`default_nettype wire

// ===== hw/rtl/mhc_front.sv =====
`default_nettype none
module mhc_front #(
    parameter int SPECIES_MAX = mhc_pkg::SPECIES_MAX_DEF
) (
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_operation,
    input  wire logic [3:0]         i_species,
    input  wire logic [3:0]         i_coeff_index,
    input  wire logic [63:0]        i_coeff_value,
    input  wire logic [63:0]        i_temperature,
    input  wire logic [63:0]        i_mass_fraction,
    input  wire logic               i_last,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output mhc_pkg::t_entry         o_entry
);
    import mhc_pkg::*;

    logic              sp_ok, ci_ok, t_nan, pos, low, high;
    logic [ADDR_W-1:0] row;

    // Classify temperature range and species
    always_comb begin
        sp_ok = {5'd0, i_species} < 9'(SPECIES_MAX);
        ci_ok = i_coeff_index < 4'(NCOEF);
        t_nan = (&i_temperature[62:52]) && (|i_temperature[51:0]);
        pos   = !i_temperature[63] && !t_nan;
        low   = pos && (i_temperature[62:0] > T_200_BITS[62:0])
                    && (i_temperature[62:0] <= T_1000_BITS[62:0]);
        high  = pos && (i_temperature[62:0] > T_1000_BITS[62:0])
                    && (i_temperature[62:0] < T_5000_BITS[62:0]);
        row   = ADDR_W'(i_species) * ADDR_W'(NCOEF);

        o_entry.last = i_last;
        o_entry.frac = i_mass_fraction;
        if (i_operation == OP_LOAD) begin
            o_entry.kind = K_LOAD;
            o_entry.addr = row + ADDR_W'(i_coeff_index);
            o_entry.data = i_coeff_value;
        end else begin
            o_entry.kind = (sp_ok && (low || high)) ? K_TERM : K_ZERO;
            o_entry.addr = high ? row + ADDR_W'(COEF_HIGH_OFS) : row;
            o_entry.data = i_temperature;
        end
    end

    // Drop loads that address nothing
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full
                        && ((i_operation == OP_ACCUM) || (sp_ok && ci_ok));

endmodule
`default_nettype wire

// ===== hw/rtl/mhc_back.sv =====
`default_nettype none
module mhc_back #(
    parameter int SPECIES_MAX = mhc_pkg::SPECIES_MAX_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [63:0]        i_gas,
    input  wire logic               i_q_valid,
    input  wire mhc_pkg::t_entry    i_q_data,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [63:0]             o_heat_capacity
);
    import mhc_pkg::*;

    localparam int DEPTH = SPECIES_MAX * NCOEF;
    localparam int MAW   = $clog2(DEPTH);
    localparam logic [3:0] STEP_SUM = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        SRC_T, SRC_Y, SRC_T2, SRC_T3, SRC_T4, SRC_P, SRC_A, SRC_SUM,
        SRC_C0, SRC_C1, SRC_C2, SRC_C3, SRC_C4, SRC_R
    } t_src;

    typedef enum logic [2:0] {
        DST_T2, DST_T3, DST_T4, DST_A, DST_P, DST_SUM
    } t_dst;

    typedef struct packed {
        logic is_add;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_uop;

    // Evaluation program: powers, Horner-free sum, scale, accumulate
    function automatic t_uop uop(input logic [3:0] step);
        t_uop u;
        case (step)
            4'd0:    u = '{1'b0, SRC_T,   SRC_T,  DST_T2};
            4'd1:    u = '{1'b0, SRC_T2,  SRC_T,  DST_T3};
            4'd2:    u = '{1'b0, SRC_T3,  SRC_T,  DST_T4};
            4'd3:    u = '{1'b0, SRC_C1,  SRC_T,  DST_A};
            4'd4:    u = '{1'b1, SRC_C0,  SRC_A,  DST_P};
            4'd5:    u = '{1'b0, SRC_C2,  SRC_T2, DST_A};
            4'd6:    u = '{1'b1, SRC_P,   SRC_A,  DST_P};
            4'd7:    u = '{1'b0, SRC_C3,  SRC_T3, DST_A};
            4'd8:    u = '{1'b1, SRC_P,   SRC_A,  DST_P};
            4'd9:    u = '{1'b0, SRC_C4,  SRC_T4, DST_A};
            4'd10:   u = '{1'b1, SRC_P,   SRC_A,  DST_P};
            4'd11:   u = '{1'b0, SRC_R,   SRC_P,  DST_P};
            4'd12:   u = '{1'b0, SRC_Y,   SRC_P,  DST_A};
            default: u = '{1'b1, SRC_SUM, SRC_A,  DST_SUM};
        endcase
        return u;
    endfunction

    t_state             r_state;
    logic [3:0]         r_step;
    logic [2:0]         r_cnt;
    logic [ADDR_W-1:0]  r_base;
    logic               r_last;
    logic [63:0]        r_t, r_y, r_t2, r_t3, r_t4, r_p, r_a, r_sum;
    logic [63:0]        r_c [5];
    logic [63:0]        r_out;
    logic               r_out_valid;

    logic [63:0]        r_mem [DEPTH];
    logic [63:0]        r_rd;
    logic [ADDR_W-1:0]  rd_addr;

    t_uop        cur;
    logic [63:0] op_a, op_b, res;
    logic        mul_start, add_start, mul_done, add_done, done;
    logic [63:0] mul_res, add_res;

    function automatic logic [63:0] pick(
        input t_src s, input logic [63:0] t, input logic [63:0] y,
        input logic [63:0] t2, input logic [63:0] t3, input logic [63:0] t4,
        input logic [63:0] p, input logic [63:0] a, input logic [63:0] sum,
        input logic [63:0] c0, input logic [63:0] c1, input logic [63:0] c2,
        input logic [63:0] c3, input logic [63:0] c4, input logic [63:0] r);
        logic [63:0] v;
        case (s)
            SRC_T:   v = t;
            SRC_Y:   v = y;
            SRC_T2:  v = t2;
            SRC_T3:  v = t3;
            SRC_T4:  v = t4;
            SRC_P:   v = p;
            SRC_A:   v = a;
            SRC_SUM: v = sum;
            SRC_C0:  v = c0;
            SRC_C1:  v = c1;
            SRC_C2:  v = c2;
            SRC_C3:  v = c3;
            SRC_C4:  v = c4;
            SRC_R:   v = r;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Decode current step and steer operands
    always_comb begin
        cur  = uop(r_step);
        op_a = pick(cur.src_a, r_t, r_y, r_t2, r_t3, r_t4, r_p, r_a, r_sum,
                    r_c[0], r_c[1], r_c[2], r_c[3], r_c[4], i_gas);
        op_b = pick(cur.src_b, r_t, r_y, r_t2, r_t3, r_t4, r_p, r_a, r_sum,
                    r_c[0], r_c[1], r_c[2], r_c[3], r_c[4], i_gas);
        mul_start = (r_state == ST_ISSUE) && !cur.is_add;
        add_start = (r_state == ST_ISSUE) && cur.is_add;
        done      = cur.is_add ? add_done : mul_done;
        res       = cur.is_add ? add_res : mul_res;
        rd_addr   = r_base + ADDR_W'(r_cnt);
    end

    mhc_fpmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    mhc_fpadd u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (add_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (add_done),
        .o_res   (add_res)
    );

    assign o_pop = (r_state == ST_IDLE) && i_q_valid;

    // Coefficient table: load writes, registered fetch reads
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_data.kind == K_LOAD)) begin
            r_mem[i_q_data.addr[MAW-1:0]] <= i_q_data.data;
        end
        r_rd <= r_mem[rd_addr[MAW-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_data.kind)
                            K_TERM: begin
                                r_base  <= i_q_data.addr;
                                r_t     <= i_q_data.data;
                                r_y     <= i_q_data.frac;
                                r_last  <= i_q_data.last;
                                r_cnt   <= '0;
                                r_state <= ST_FETCH;
                            end
                            K_ZERO: begin
                                r_a     <= '0;
                                r_last  <= i_q_data.last;
                                r_step  <= STEP_SUM;
                                r_state <= ST_ISSUE;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_FETCH: begin
                    if (r_cnt != 3'd0) begin
                        r_c[r_cnt - 3'd1] <= r_rd;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        r_step  <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (done) begin
                        case (cur.dst)
                            DST_T2:  r_t2  <= res;
                            DST_T3:  r_t3  <= res;
                            DST_T4:  r_t4  <= res;
                            DST_A:   r_a   <= res;
                            DST_P:   r_p   <= res;
                            DST_SUM: r_sum <= res;
                            default: r_p   <= res;
                        endcase
                        if (r_step == STEP_SUM) begin
                            r_state <= r_last ? ST_EMIT : ST_IDLE;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_sum;
                        r_out_valid <= 1'b1;
                        r_sum       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_heat_capacity = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/mixture_heat_capacity_core.sv =====
`default_nettype none
// Mixture heat capacity in IEEE double precision. Load items (operation 0)
// write one of ten cp polynomial coefficients of a species into a table;
// accumulate items (operation 1) add Y*R*(c0+c1*T+...+c4*T^4) to a running
// sum, using slots 0-4 for 200<T<=1000 and 5-9 for 1000<T<5000, zero
// otherwise; an accumulate item with last set delivers the sum and clears
// it. R is written at APB address 0 before use. Items enter a two-entry
// queue; a load is retired without computation, a term outside the ranges
// runs only the final accumulate, and a full term takes five table reads,
// then fourteen dependent operations on one shared multi-cycle multiplier
// and one adder. Round-to-nearest-even with subnormals is kept throughout.
// Table entries never loaded read back as undefined values.
module mixture_heat_capacity_core #(
    parameter int SPECIES_MAX = mhc_pkg::SPECIES_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mhc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_operation,
    input  wire logic [3:0]                    i_species,
    input  wire logic [3:0]                    i_coeff_index,
    input  wire logic [63:0]                   i_coeff_value,
    input  wire logic [63:0]                   i_temperature,
    input  wire logic [63:0]                   i_mass_fraction,
    input  wire logic                          i_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [63:0]                        o_heat_capacity
);
    import mhc_pkg::*;

    logic [63:0] r_gas;
    logic        push, full, pop, q_valid;
    t_entry      entry, head;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas <= '0;
        end else if (psel && penable && pwrite
                     && (paddr[PADDR_W-1] == REG_GAS_CONSTANT)) begin
            r_gas <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_GAS_CONSTANT) ? r_gas : 64'd0;

    mhc_front #(.SPECIES_MAX(SPECIES_MAX)) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_species       (i_species),
        .i_coeff_index   (i_coeff_index),
        .i_coeff_value   (i_coeff_value),
        .i_temperature   (i_temperature),
        .i_mass_fraction (i_mass_fraction),
        .i_last          (i_last),
        .i_q_full        (full),
        .o_push          (push),
        .o_entry         (entry)
    );

    mhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head)
    );

    mhc_back #(.SPECIES_MAX(SPECIES_MAX)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_gas           (r_gas),
        .i_q_valid       (q_valid),
        .i_q_data        (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_heat_capacity (o_heat_capacity)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mhc_pkg::*;

    localparam int NSPECIES   = 16;
    localparam int DRAIN_WAIT = 250;
    localparam int IDLE_LIMIT = 6000;

    typedef struct {
        logic        op;
        logic [3:0]  species;
        logic [3:0]  cidx;
        logic [63:0] cval;
        logic [63:0] temp;
        logic [63:0] frac;
        logic        last;
    } cp_item_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [63:0]         pwdata = '0;
    logic [63:0]         prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_operation = 1'b0;
    logic [3:0]          i_species = '0;
    logic [3:0]          i_coeff_index = '0;
    logic [63:0]         i_coeff_value = '0;
    logic [63:0]         i_temperature = '0;
    logic [63:0]         i_mass_fraction = '0;
    logic                i_last = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [63:0]         o_heat_capacity;

    mixture_heat_capacity_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_species(i_species),
        .i_coeff_index(i_coeff_index), .i_coeff_value(i_coeff_value),
        .i_temperature(i_temperature), .i_mass_fraction(i_mass_fraction),
        .i_last(i_last),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_heat_capacity(o_heat_capacity)
    );

    always #5 i_clk = ~i_clk;

    cp_item_t    pending_items[$];
    logic [63:0] expected_cp[$];
    int          fail_count = 0;
    int          idle_cycles = 0;

    // Predictor state
    logic [63:0] coef_tbl[NSPECIES][NCOEF];
    logic [63:0] gas_r = '0;
    real         cp_sum = 0.0;

    function automatic bit is_nan(input logic [63:0] b);
        return b[62:52] == 11'h7FF && b[51:0] != '0;
    endfunction

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    function automatic real rand_real(input real lo, input real hi);
        return lo + (hi - lo) * ($urandom / 4294967295.0);
    endfunction

    // Species term in the same evaluation order as the block
    function automatic real species_cp(input logic [3:0] sp, input real t, input real y);
        int  base;
        real t2, t3, t4, p;
        if (t > 200.0 && t <= 1000.0) base = 0;
        else if (t > 1000.0 && t < 5000.0) base = COEF_HIGH_OFS;
        else return 0.0;
        t2 = t * t;
        t3 = t2 * t;
        t4 = t3 * t;
        p = $bitstoreal(coef_tbl[sp][base]) + $bitstoreal(coef_tbl[sp][base+1]) * t;
        p = p + $bitstoreal(coef_tbl[sp][base+2]) * t2;
        p = p + $bitstoreal(coef_tbl[sp][base+3]) * t3;
        p = p + $bitstoreal(coef_tbl[sp][base+4]) * t4;
        p = $bitstoreal(gas_r) * p;
        return y * p;
    endfunction

    // Advance the predictor by one accepted transfer
    function automatic void predict_cp(input cp_item_t it);
        if (it.op == OP_LOAD) begin
            if (it.cidx < NCOEF) coef_tbl[it.species][it.cidx] = it.cval;
        end else begin
            cp_sum = cp_sum + species_cp(it.species, $bitstoreal(it.temp),
                                         $bitstoreal(it.frac));
            if (it.last) begin
                expected_cp.push_back($realtobits(cp_sum));
                cp_sum = 0.0;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic cp_item_t mk_load(input logic [3:0] sp, input logic [3:0] ci,
                                         input logic [63:0] v, input logic lst);
        cp_item_t it;
        it.op = OP_LOAD; it.species = sp; it.cidx = ci; it.cval = v;
        it.temp = rand_bits(); it.frac = rand_bits(); it.last = lst;
        return it;
    endfunction

    function automatic cp_item_t mk_accum(input logic [3:0] sp, input logic [63:0] t,
                                          input logic [63:0] y, input logic lst);
        cp_item_t it;
        it.op = OP_ACCUM; it.species = sp; it.cidx = 4'($urandom); it.cval = rand_bits();
        it.temp = t; it.frac = y; it.last = lst;
        return it;
    endfunction

    // Plausible coefficient for a slot, occasionally raw bits
    function automatic logic [63:0] coef_value(input int ci);
        real scale;
        if ($urandom_range(0, 19) == 0) return rand_bits();
        case (ci % 5)
            0: scale = 4.0;
            1: scale = 1.0e-2;
            2: scale = 1.0e-5;
            3: scale = 1.0e-9;
            default: scale = 1.0e-13;
        endcase
        return $realtobits(rand_real(-scale, scale));
    endfunction

    function automatic logic [63:0] rand_temp();
        case ($urandom_range(0, 9))
            0: return rand_bits();
            1: return $realtobits(rand_real(0.0, 6000.0));
            2: return $realtobits(rand_real(1000.0, 4999.0));
            default: return $realtobits(rand_real(200.5, 1000.0));
        endcase
    endfunction

    function automatic logic [63:0] rand_frac();
        if ($urandom_range(0, 15) == 0) return rand_bits();
        return $realtobits(rand_real(0.0, 1.0));
    endfunction

    task automatic queue_random(input int n);
        int k, terms;
        k = 0;
        while (k < n) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_items.push_back(mk_load(4'($urandom), 4'($urandom), rand_bits(),
                                                1'($urandom)));
                k++;
            end else if ($urandom_range(0, 5) == 0) begin
                pending_items.push_back(mk_load(4'($urandom), 4'($urandom_range(0, 9)),
                                                coef_value($urandom_range(0, 9)),
                                                1'($urandom)));
                k++;
            end else begin
                terms = $urandom_range(1, 5);
                for (int j = 0; j < terms; j++) begin
                    pending_items.push_back(mk_accum(4'($urandom), rand_temp(), rand_frac(),
                                                     j == terms - 1));
                end
                k += terms;
            end
        end
    endtask

    task automatic apb_write(input logic [63:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'(8 * REG_GAS_CONSTANT); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        gas_r = v;
    endtask

    // Hold until all transfers and results are done, then let the pipe settle
    task automatic drain();
        while (pending_items.size() != 0 || i_in_valid || expected_cp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Driver: bursts of transfers with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge i_clk) begin
        cp_item_t it;
        if (i_in_valid && o_in_ready) predict_cp('{i_operation, i_species, i_coeff_index,
                                                   i_coeff_value, i_temperature,
                                                   i_mass_fraction, i_last});
        if (i_rst_n && (!i_in_valid || o_in_ready)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_operation <= it.op; i_species <= it.species; i_coeff_index <= it.cidx;
                i_coeff_value <= it.cval; i_temperature <= it.temp;
                i_mass_fraction <= it.frac; i_last <= it.last;
                i_in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a rotating pattern, reseeded now and then
    logic [15:0] stall_pat = 16'hFFFF;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        i_out_ready <= i_rst_n & stall_pat[0];
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_cp.size() == 0) begin
                report_mismatch($sformatf("unexpected heat_capacity %h", o_heat_capacity));
            end else begin
                want = expected_cp.pop_front();
                if (o_heat_capacity !== want && !(is_nan(want) && is_nan(o_heat_capacity)))
                    report_mismatch($sformatf("heat_capacity %h, expected %h",
                                              o_heat_capacity, want));
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic [63:0] r_gas;
        for (int s = 0; s < NSPECIES; s++)
            for (int c = 0; c < NCOEF; c++) coef_tbl[s][c] = '0;
        r_gas = $realtobits(8.314462618);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_write(r_gas);

        // Load every coefficient so no unwritten entry is ever read
        for (int s = 0; s < NSPECIES; s++)
            for (int c = 0; c < NCOEF; c++)
                pending_items.push_back(mk_load(4'(s), 4'(c), coef_value(c), 1'b0));

        // Directed: range bounds, special temperatures, ignored loads
        pending_items.push_back(mk_accum(4'd0, T_200_BITS, $realtobits(1.0), 1'b1));
        pending_items.push_back(mk_accum(4'd1, $realtobits(200.00001), $realtobits(0.5), 1'b0));
        pending_items.push_back(mk_accum(4'd2, T_1000_BITS, $realtobits(0.25), 1'b0));
        pending_items.push_back(mk_accum(4'd3, T_1000_BITS + 1, $realtobits(0.25), 1'b1));
        pending_items.push_back(mk_accum(4'd4, T_5000_BITS - 1, $realtobits(1.0), 1'b1));
        pending_items.push_back(mk_accum(4'd5, T_5000_BITS, $realtobits(1.0), 1'b1));
        pending_items.push_back(mk_accum(4'd15, DEFAULT_QNAN, $realtobits(1.0), 1'b1));
        pending_items.push_back(mk_accum(4'd6, 64'h7FF0_0000_0000_0000, 64'h0, 1'b1));
        pending_items.push_back(mk_accum(4'd7, $realtobits(-300.0), $realtobits(1.0), 1'b1));
        pending_items.push_back(mk_accum(4'd8, 64'h0, 64'h0, 1'b1));
        pending_items.push_back(mk_accum(4'd9, 64'hFFFF_FFFF_FFFF_FFFF,
                                         64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        pending_items.push_back(mk_accum(4'd10, $realtobits(500.0), 64'h8000_0000_0000_0000,
                                         1'b1));
        pending_items.push_back(mk_accum(4'd11, $realtobits(700.0), 64'h0000_0000_0000_0001,
                                         1'b1));
        pending_items.push_back(mk_load(4'd12, 4'd10, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        pending_items.push_back(mk_load(4'd13, 4'd15, 64'h0, 1'b0));
        pending_items.push_back(mk_load(4'd14, 4'd9, $realtobits(1.0e-14), 1'b1));
        pending_items.push_back(mk_accum(4'd14, $realtobits(4000.0), $realtobits(0.75), 1'b0));
        pending_items.push_back(mk_accum(4'd12, $realtobits(2500.0), $realtobits(0.125), 1'b1));
        drain();

        queue_random(220);
        drain();
        apb_write(64'hFFFF_FFFF_FFFF_FFFF);
        queue_random(100);
        drain();
        apb_write(64'h0);
        queue_random(100);
        drain();
        apb_write(64'h7FEF_FFFF_FFFF_FFFF);
        queue_random(100);
        drain();
        apb_write($realtobits(rand_real(1.0, 20.0)));
        queue_random(220);
        drain();

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
